// ===== rtl/etsc_pkg.sv =====
`default_nettype none

package etsc_pkg;

   // Configuration register indexes and reset values
   localparam logic       CSR_EPOCH_YEAR   = 1'b0;
   localparam logic       CSR_TZ_OFFSET    = 1'b1;
   localparam logic [13:0] EPOCH_YEAR_RESET = 14'd1970;
   localparam logic [4:0]  TZ_OFFSET_RESET  = 5'd0;

   localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
   localparam logic [9:0]  DAYS_PER_YEAR  = 10'd365;
   localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

   // Constant divider operations
   typedef logic [2:0] dop_type;
   localparam dop_type DOP_60  = 3'd0;
   localparam dop_type DOP_24  = 3'd1;
   localparam dop_type DOP_365 = 3'd2;
   localparam dop_type DOP_100 = 3'd3;
   localparam dop_type DOP_400 = 3'd4;

   // Where the datapath stores a divider result
   typedef logic [3:0] cap_type;
   localparam cap_type CAP_NONE = 4'd0;
   localparam cap_type CAP_SEC  = 4'd1;
   localparam cap_type CAP_MIN  = 4'd2;
   localparam cap_type CAP_HR   = 4'd3;
   localparam cap_type CAP_YD   = 4'd4;
   localparam cap_type CAP_ACC  = 4'd5;
   localparam cap_type CAP_BASE = 4'd6;
   localparam cap_type CAP_YLB  = 4'd7;
   localparam cap_type CAP_L100 = 4'd8;
   localparam cap_type CAP_L400 = 4'd9;

   typedef struct packed {
      logic    load;
      logic    mul;
      dop_type dop;
      cap_type cap;
      logic    month_step;
   } cmd_type;

   typedef struct packed {
      logic step_back;
      logic month_go;
   } sts_type;

   // Right shift applied before the reciprocal multiply
   function automatic logic [2:0] dop_pre(input dop_type dop);
      logic [2:0] pre;
      unique case (dop)
         DOP_60:  pre = 3'd2;
         DOP_24:  pre = 3'd3;
         DOP_100: pre = 3'd2;
         DOP_400: pre = 3'd4;
         default: pre = 3'd0;
      endcase
      return pre;
   endfunction

   // Reciprocals: /15 and /25 exact over 32 bits, /3 exact over 32 bits,
   // /365 exact below 2^16
   function automatic logic [31:0] dop_magic(input dop_type dop);
      logic [31:0] magic;
      unique case (dop)
         DOP_60:  magic = 32'h8888_8889;
         DOP_24:  magic = 32'hAAAA_AAAB;
         DOP_365: magic = 32'd91930;
         default: magic = 32'h51EB_851F;
      endcase
      return magic;
   endfunction

   function automatic logic [5:0] dop_shift(input dop_type dop);
      logic [5:0] sh;
      unique case (dop)
         DOP_24:  sh = 6'd33;
         DOP_365: sh = 6'd25;
         default: sh = 6'd35;
      endcase
      return sh;
   endfunction

   function automatic logic [8:0] dop_divisor(input dop_type dop);
      logic [8:0] d;
      unique case (dop)
         DOP_60:  d = 9'd60;
         DOP_24:  d = 9'd24;
         DOP_365: d = 9'd365;
         DOP_100: d = 9'd100;
         default: d = 9'd400;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd1:                     len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/etsc_cdiv.sv =====
`default_nettype none

module etsc_cdiv
   import etsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        mul_en,
   input  wire dop_type     dop,
   input  wire logic [31:0] operand,
   output logic      [31:0] quotient,
   output logic      [8:0]  remainder
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [31:0] scaled;
   logic [63:0] shifted;
   logic [31:0] qd;
   logic [31:0] diff;

   // Multiply stage: scaled operand times reciprocal, registered in prod_ff
   always_comb begin
      scaled  = operand >> dop_pre(dop);
      prod_in = mul_en ? (64'(scaled) * 64'(dop_magic(dop))) : prod_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Result stage: quotient from the registered product, remainder by back-multiply
   always_comb begin
      shifted   = prod_ff >> dop_shift(dop);
      quotient  = shifted[31:0];
      qd        = quotient * {23'd0, dop_divisor(dop)};
      diff      = operand - qd;
      remainder = diff[8:0];
   end

endmodule

`default_nettype wire

// ===== rtl/etsc_dp.sv =====
`default_nettype none

module etsc_dp
   import etsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [13:0] csr_wdata,
   input  wire logic [31:0] req_seconds,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic      [13:0] rsp_year,
   output logic      [3:0]  rsp_month,
   output logic      [4:0]  rsp_day_of_month,
   output logic      [4:0]  rsp_hour,
   output logic      [5:0]  rsp_minute,
   output logic      [5:0]  rsp_second_of_minute
);

   logic [13:0] epoch_ff, epoch_in;
   logic [4:0]  tz_ff, tz_in;
   logic [31:0] n_ff, n_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hr_ff, hr_in;
   logic [14:0] year_ff, year_in;
   logic [9:0]  day_ff, day_in;
   logic [12:0] acc_ff, acc_in;
   logic [12:0] base_ff, base_in;
   logic        zy_ff, zy_in;
   logic        r100z_ff, r100z_in;
   logic        leap_ff, leap_in;
   logic [3:0]  m_ff, m_in;

   logic [31:0] div_q;
   logic [8:0]  div_r;
   logic [31:0] tz_ext;
   logic [31:0] offset_secs;
   logic [12:0] lb;
   logic [12:0] leaps;
   logic [9:0]  day_adj;
   logic [4:0]  cur_len;
   logic [14:0] year_m1;
   logic [14:0] year_m2;
   logic [14:0] epoch_m1;

   etsc_cdiv u_cdiv (
      .clock     (clock),
      .mul_en    (cmd.mul),
      .dop       (cmd.dop),
      .operand   (n_ff),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      tz_ext      = {{27{tz_ff[4]}}, tz_ff};
      offset_secs = tz_ext * SECS_PER_HOUR;
      lb          = zy_ff ? 13'd0 : (acc_ff + div_q[12:0]);
      leaps       = lb - base_ff;
      day_adj     = ({3'd0, day_ff} >= leaps) ? (day_ff - leaps[9:0]) : 10'd0;
      cur_len     = month_len(leap_ff, m_ff);
      year_m1     = year_ff - 15'd1;
      year_m2     = year_ff - 15'd2;
      epoch_m1    = {1'b0, epoch_ff} - 15'd1;
      sts.step_back = ({3'd0, day_ff} < leaps) && (year_ff > {1'b0, epoch_ff});
      sts.month_go  = (m_ff < LAST_MONTH_IDX) && (day_ff >= {5'd0, cur_len});
   end

   always_comb begin
      epoch_in = epoch_ff;
      tz_in    = tz_ff;
      n_in     = n_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hr_in    = hr_ff;
      year_in  = year_ff;
      day_in   = day_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      zy_in    = zy_ff;
      r100z_in = r100z_ff;
      leap_in  = leap_ff;
      m_in     = m_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_EPOCH_YEAR: epoch_in = csr_wdata;
            CSR_TZ_OFFSET:  tz_in    = csr_wdata[4:0];
            default:        epoch_in = epoch_ff;
         endcase
      end

      if (cmd.load) begin
         n_in = req_seconds + offset_secs;
      end

      unique case (cmd.cap)
         CAP_SEC: begin
            sec_in = div_r[5:0];
            n_in   = div_q;
         end
         CAP_MIN: begin
            min_in = div_r[5:0];
            n_in   = div_q;
         end
         CAP_HR: begin
            hr_in = div_r[4:0];
            n_in  = div_q;
         end
         CAP_YD: begin
            year_in = {1'b0, epoch_ff} + div_q[14:0];
            day_in  = {1'b0, div_r};
            n_in    = {17'd0, epoch_m1};
            zy_in   = (epoch_ff == 14'd0);
         end
         CAP_ACC: begin
            acc_in = n_ff[14:2] - div_q[12:0] + 13'd1;
         end
         CAP_BASE: begin
            base_in = lb;
            n_in    = {17'd0, year_m1};
            zy_in   = (year_ff == 15'd0);
         end
         CAP_YLB: begin
            if (sts.step_back) begin
               year_in = year_m1;
               day_in  = day_ff + DAYS_PER_YEAR;
               n_in    = {17'd0, year_m2};
               zy_in   = (year_m1 == 15'd0);
            end else begin
               day_in = day_adj;
               n_in   = {17'd0, year_ff};
            end
         end
         CAP_L100: begin
            r100z_in = (div_r == 9'd0);
         end
         CAP_L400: begin
            leap_in = ((year_ff[1:0] == 2'd0) && !r100z_ff) || (div_r == 9'd0);
            m_in    = 4'd0;
         end
         default: begin
            n_in = n_in;
         end
      endcase

      if (cmd.month_step && sts.month_go) begin
         day_in = day_ff - {5'd0, cur_len};
         m_in   = m_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EPOCH_YEAR_RESET;
         tz_ff    <= TZ_OFFSET_RESET;
      end else begin
         epoch_ff <= epoch_in;
         tz_ff    <= tz_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hr_ff    <= hr_in;
      year_ff  <= year_in;
      day_ff   <= day_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      zy_ff    <= zy_in;
      r100z_ff <= r100z_in;
      leap_ff  <= leap_in;
      m_ff     <= m_in;
   end

   always_comb begin
      rsp_year             = year_ff[13:0];
      rsp_month            = m_ff + 4'd1;
      rsp_day_of_month     = day_ff[4:0] + 5'd1;
      rsp_hour             = hr_ff;
      rsp_minute           = min_ff;
      rsp_second_of_minute = sec_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/etsc_ctrl.sv =====
`default_nettype none

module etsc_ctrl
   import etsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_strobe
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_M60A  = 5'd1;
   localparam logic [4:0] ST_C60A  = 5'd2;
   localparam logic [4:0] ST_M60B  = 5'd3;
   localparam logic [4:0] ST_C60B  = 5'd4;
   localparam logic [4:0] ST_M24   = 5'd5;
   localparam logic [4:0] ST_C24   = 5'd6;
   localparam logic [4:0] ST_M365  = 5'd7;
   localparam logic [4:0] ST_C365  = 5'd8;
   localparam logic [4:0] ST_BM100 = 5'd9;
   localparam logic [4:0] ST_BC100 = 5'd10;
   localparam logic [4:0] ST_BM400 = 5'd11;
   localparam logic [4:0] ST_BC400 = 5'd12;
   localparam logic [4:0] ST_YM100 = 5'd13;
   localparam logic [4:0] ST_YC100 = 5'd14;
   localparam logic [4:0] ST_YM400 = 5'd15;
   localparam logic [4:0] ST_YC400 = 5'd16;
   localparam logic [4:0] ST_LM100 = 5'd17;
   localparam logic [4:0] ST_LC100 = 5'd18;
   localparam logic [4:0] ST_LM400 = 5'd19;
   localparam logic [4:0] ST_LC400 = 5'd20;
   localparam logic [4:0] ST_MONTH = 5'd21;
   localparam logic [4:0] ST_DONE  = 5'd22;

   logic [4:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_M60A;
            end
         end
         ST_M60A: begin
            cmd.mul = 1'b1; cmd.dop = DOP_60; state_in = ST_C60A;
         end
         ST_C60A: begin
            cmd.dop = DOP_60; cmd.cap = CAP_SEC; state_in = ST_M60B;
         end
         ST_M60B: begin
            cmd.mul = 1'b1; cmd.dop = DOP_60; state_in = ST_C60B;
         end
         ST_C60B: begin
            cmd.dop = DOP_60; cmd.cap = CAP_MIN; state_in = ST_M24;
         end
         ST_M24: begin
            cmd.mul = 1'b1; cmd.dop = DOP_24; state_in = ST_C24;
         end
         ST_C24: begin
            cmd.dop = DOP_24; cmd.cap = CAP_HR; state_in = ST_M365;
         end
         ST_M365: begin
            cmd.mul = 1'b1; cmd.dop = DOP_365; state_in = ST_C365;
         end
         ST_C365: begin
            cmd.dop = DOP_365; cmd.cap = CAP_YD; state_in = ST_BM100;
         end
         ST_BM100: begin
            cmd.mul = 1'b1; cmd.dop = DOP_100; state_in = ST_BC100;
         end
         ST_BC100: begin
            cmd.dop = DOP_100; cmd.cap = CAP_ACC; state_in = ST_BM400;
         end
         ST_BM400: begin
            cmd.mul = 1'b1; cmd.dop = DOP_400; state_in = ST_BC400;
         end
         ST_BC400: begin
            cmd.dop = DOP_400; cmd.cap = CAP_BASE; state_in = ST_YM100;
         end
         ST_YM100: begin
            cmd.mul = 1'b1; cmd.dop = DOP_100; state_in = ST_YC100;
         end
         ST_YC100: begin
            cmd.dop = DOP_100; cmd.cap = CAP_ACC; state_in = ST_YM400;
         end
         ST_YM400: begin
            cmd.mul = 1'b1; cmd.dop = DOP_400; state_in = ST_YC400;
         end
         ST_YC400: begin
            cmd.dop  = DOP_400;
            cmd.cap  = CAP_YLB;
            state_in = sts.step_back ? ST_YM100 : ST_LM100;
         end
         ST_LM100: begin
            cmd.mul = 1'b1; cmd.dop = DOP_100; state_in = ST_LC100;
         end
         ST_LC100: begin
            cmd.dop = DOP_100; cmd.cap = CAP_L100; state_in = ST_LM400;
         end
         ST_LM400: begin
            cmd.mul = 1'b1; cmd.dop = DOP_400; state_in = ST_LC400;
         end
         ST_LC400: begin
            cmd.dop = DOP_400; cmd.cap = CAP_L400; state_in = ST_MONTH;
         end
         ST_MONTH: begin
            cmd.month_step = 1'b1;
            state_in       = sts.month_go ? ST_MONTH : ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_DONE);
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_M60A))
      else $error("accepted transaction did not start the divide sequence");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe not followed by idle");

   a_month_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MONTH) && !sts.month_go) |=> rsp_strobe)
      else $error("month walk ended without a result");

   a_load_idle_only: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (start && !busy))
      else $error("operand loaded outside an accepted transaction");

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_top.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         start & !busy        req_seconds
// response  out        rsp_strobe (1 cycle) rsp_year, rsp_month, rsp_day_of_month,
//                                           rsp_hour, rsp_minute, rsp_second_of_minute
// csr       in         csr_we               csr_index, csr_wdata
//
// rsp_strobe rises once the divisions and the month walk are done; busy drops
// in the cycle after it, and a new request is taken only while busy is low.
// Each division runs on the shared reciprocal divider as a multiply and a
// capture step (ten divisions, twelve when the year steps back); the month walk
// then goes one month per cycle. Reset is synchronous and active high; it
// returns the sequencer to idle and loads epoch year 1970 and a zero timezone
// offset. Results on the rsp_ ports hold from the strobe cycle until the next
// request; the receiver cannot stall. Write the csr port only while busy is low.

module epoch_seconds_to_calendar_top
   import etsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_seconds,
   // response
   output logic             rsp_strobe,
   output logic      [13:0] rsp_year,
   output logic      [3:0]  rsp_month,
   output logic      [4:0]  rsp_day_of_month,
   output logic      [4:0]  rsp_hour,
   output logic      [5:0]  rsp_minute,
   output logic      [5:0]  rsp_second_of_minute,
   // configuration
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [13:0] csr_wdata
);

   // Command and status between the sequencer and the datapath
   cmd_type cmd;
   sts_type sts;

   // Sequencer: steps the divider through seconds, minutes, hours, days, the year
   // estimate, the leap-day step-back and the leap-year test, then walks the months
   etsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Datapath: config registers, working registers, shared divider
   etsc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_seconds          (req_seconds),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_year             (rsp_year),
      .rsp_month            (rsp_month),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour             (rsp_hour),
      .rsp_minute           (rsp_minute),
      .rsp_second_of_minute (rsp_second_of_minute)
   );

endmodule

`default_nettype wire
